@@ hdl/ipf_pkg.sv @@
// ----------------------------------------------------------------------------
// IR proximity filter package
// Shared widths, register indexes, range codes, reset values and the
// configuration, scan and result bundle types.
// ----------------------------------------------------------------------------
`default_nettype none

package ipf_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 8;

    localparam int unsigned RANGE_W  = 2;
    localparam int unsigned ECHO_W   = 4;
    localparam int unsigned FILTER_W = 4;
    localparam int unsigned OBS_W    = 10;
    localparam int unsigned DUTY_W   = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_LEVEL       = 3'd0,
        REG_ECHO_TRIGGER      = 3'd1,
        REG_FILTER_LIMIT      = 3'd2,
        REG_FILTER_REARM      = 3'd3,
        REG_OBSTRUCTION_LIMIT = 3'd4,
        REG_FAR_DUTY_FLOOR    = 3'd5,
        REG_NEAR_DUTY_FLOOR   = 3'd6
    } t_reg_idx;

    localparam logic [RANGE_W-1:0] RANGE_OFF  = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_NEAR = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_FAR  = 2'd2;

    localparam logic [RANGE_W-1:0]  RST_RANGE_LEVEL       = RANGE_OFF;
    localparam logic [ECHO_W-1:0]   RST_ECHO_TRIGGER      = 4'd9;
    localparam logic [FILTER_W-1:0] RST_FILTER_LIMIT      = 4'd7;
    localparam logic [FILTER_W-1:0] RST_FILTER_REARM      = 4'd2;
    localparam logic [OBS_W-1:0]    RST_OBSTRUCTION_LIMIT = 10'd257;
    localparam logic [DUTY_W-1:0]   RST_FAR_DUTY_FLOOR    = 6'd22;
    localparam logic [DUTY_W-1:0]   RST_NEAR_DUTY_FLOOR   = 6'd13;

    localparam logic [FILTER_W-1:0] RST_FILTER_COUNT      = 4'd2;
    localparam logic [OBS_W-1:0]    RST_OBSTRUCTION_COUNT = 10'd0;
    localparam logic [DUTY_W-1:0]   RST_FAR_DUTY          = 6'd32;
    localparam logic [DUTY_W-1:0]   RST_NEAR_DUTY         = 6'd20;

    typedef struct packed {
        logic [RANGE_W-1:0]  range_level;
        logic [ECHO_W-1:0]   echo_trigger;
        logic [FILTER_W-1:0] filter_limit;
        logic [FILTER_W-1:0] filter_rearm;
        logic [OBS_W-1:0]    obstruction_limit;
        logic [DUTY_W-1:0]   far_duty_floor;
        logic [DUTY_W-1:0]   near_duty_floor;
    } t_cfg;

    typedef struct packed {
        logic               skip_scan;
        logic               probe_echo;
        logic [ECHO_W-1:0]  burst_echoes;
    } t_scan;

    typedef struct packed {
        logic               presence;
        logic [DUTY_W-1:0]  drive_duty;
        logic               burst_used;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/ipf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// IR proximity filter configuration registers
// Write-only register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module ipf_cfg_regs (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [ipf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [ipf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ipf_pkg::t_cfg                  o_cfg
);
    import ipf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_RANGE_LEVEL:       n_cfg.range_level       = i_cfg_data[RANGE_W-1:0];
                REG_ECHO_TRIGGER:      n_cfg.echo_trigger      = i_cfg_data[ECHO_W-1:0];
                REG_FILTER_LIMIT:      n_cfg.filter_limit      = i_cfg_data[FILTER_W-1:0];
                REG_FILTER_REARM:      n_cfg.filter_rearm      = i_cfg_data[FILTER_W-1:0];
                REG_OBSTRUCTION_LIMIT: n_cfg.obstruction_limit = i_cfg_data[OBS_W-1:0];
                REG_FAR_DUTY_FLOOR:    n_cfg.far_duty_floor    = i_cfg_data[DUTY_W-1:0];
                REG_NEAR_DUTY_FLOOR:   n_cfg.near_duty_floor   = i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_level       <= RST_RANGE_LEVEL;
            r_cfg.echo_trigger      <= RST_ECHO_TRIGGER;
            r_cfg.filter_limit      <= RST_FILTER_LIMIT;
            r_cfg.filter_rearm      <= RST_FILTER_REARM;
            r_cfg.obstruction_limit <= RST_OBSTRUCTION_LIMIT;
            r_cfg.far_duty_floor    <= RST_FAR_DUTY_FLOOR;
            r_cfg.near_duty_floor   <= RST_NEAR_DUTY_FLOOR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hdl/ipf_core.sv @@
// ----------------------------------------------------------------------------
// IR proximity filter core
// Input register, filter/obstruction/duty update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipf_core (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire ipf_pkg::t_cfg  i_cfg,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  wire ipf_pkg::t_scan i_in_scan,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output ipf_pkg::t_result o_out_result
);
    import ipf_pkg::*;

    logic                r_in_vld;
    t_scan               r_in_scan;
    logic                r_out_vld;
    t_result             r_out_result;

    logic [FILTER_W-1:0] r_filter;
    logic [OBS_W-1:0]    r_obs;
    logic [DUTY_W-1:0]   r_far;
    logic [DUTY_W-1:0]   r_near;

    logic [FILTER_W-1:0] n_filter;
    logic [OBS_W-1:0]    n_obs;
    logic [DUTY_W-1:0]   n_far;
    logic [DUTY_W-1:0]   n_near;
    t_result             n_result;

    logic out_free;
    logic advance;
    logic obs_evt;

    assign out_free   = !r_out_vld || i_out_ready;
    assign advance    = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || out_free;

    always_comb begin
        n_filter = r_filter;
        n_obs    = r_obs;
        n_far    = r_far;
        n_near   = r_near;
        n_result = '0;
        obs_evt  = 1'b0;

        if (!r_in_scan.skip_scan) begin
            if (i_cfg.range_level == RANGE_FAR) begin
                n_result.drive_duty = r_far;
            end else if (i_cfg.range_level == RANGE_NEAR) begin
                n_result.drive_duty = r_near;
            end

            if (r_in_scan.probe_echo) begin
                if (r_filter == '0) begin
                    n_result.burst_used = 1'b1;
                    if (r_in_scan.burst_echoes >= i_cfg.echo_trigger) begin
                        n_result.presence = 1'b1;
                        n_filter          = i_cfg.filter_rearm;
                    end else begin
                        obs_evt = 1'b1;
                    end
                end else begin
                    if (r_filter < i_cfg.filter_limit) begin
                        n_filter = r_filter + FILTER_W'(1);
                    end
                    obs_evt = 1'b1;
                end
            end else begin
                if (r_filter != '0) begin
                    n_filter = r_filter - FILTER_W'(1);
                end
                if (r_obs != '0) begin
                    n_obs = r_obs - OBS_W'(1);
                end
            end
        end

        // step the active range's duty down when the obstruction count tops out
        if (obs_evt) begin
            if (r_obs < i_cfg.obstruction_limit) begin
                n_obs = r_obs + OBS_W'(1);
            end else begin
                n_obs = '0;
                if (i_cfg.range_level == RANGE_FAR) begin
                    if (r_far > i_cfg.far_duty_floor) begin
                        n_far = r_far - DUTY_W'(1);
                    end
                end else if (i_cfg.range_level == RANGE_NEAR) begin
                    if (r_near > i_cfg.near_duty_floor) begin
                        n_near = r_near - DUTY_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_filter  <= RST_FILTER_COUNT;
            r_obs     <= RST_OBSTRUCTION_COUNT;
            r_far     <= RST_FAR_DUTY;
            r_near    <= RST_NEAR_DUTY;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (advance) begin
                r_filter <= n_filter;
                r_obs    <= n_obs;
                r_far    <= n_far;
                r_near   <= n_near;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_scan <= i_in_scan;
        end
        if (advance) begin
            r_out_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_result = r_out_result;

endmodule

`default_nettype wire

@@ hdl/ir_proximity_filter_autosense_unit.sv @@
// ----------------------------------------------------------------------------
// IR proximity presence filter with automatic sensitivity reduction
// An accepted scan beat is held in the input register, then its result beat
// is registered in the result register. Throughput: one scan beat per cycle
// while the result side does not stall, set by the single update stage.
// Reset: synchronous, active low; clears handshake state, loads the register
// and counter defaults (filter 2, obstruction 0, far duty 32, near duty 20).
// ----------------------------------------------------------------------------
`default_nettype none

module ir_proximity_filter_autosense_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [ipf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [ipf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // [0] skip_scan, [1] probe_echo, [5:2] burst_echoes, [7:6] zero
    input  wire [ipf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // [0] presence, [6:1] drive_duty, [7] burst_used
    output logic [ipf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ipf_pkg::*;

    t_cfg    cfg;
    t_scan   in_scan;
    t_result out_result;

    assign in_scan.skip_scan    = s_axis_tdata[0];
    assign in_scan.probe_echo   = s_axis_tdata[1];
    assign in_scan.burst_echoes = s_axis_tdata[5:2];

    ipf_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ipf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_scan    (in_scan),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_result (out_result)
    );

    assign m_axis_tdata = {out_result.burst_used, out_result.drive_duty, out_result.presence};

endmodule

`default_nettype wire

@@ hdl/ipf_checker.sv @@
// ----------------------------------------------------------------------------
// IR proximity filter port checker
// Port-level properties of the scan and result streams, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ipf_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [ipf_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import ipf_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_presence_needs_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[OUT_DATA_W-1])
        else $error("presence reported without a burst");

    a_no_backpressure_leak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("scan input stalled while result side is ready");

    a_scan_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid && !$past(s_axis_tvalid)
        |=> ##1 m_axis_tvalid)
        else $error("accepted scan beat produced no result beat");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind ir_proximity_filter_autosense_unit ipf_checker u_ipf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
